// File: hw/rtl/mld_pkg.sv
// Package for the magic-header deframer: types, codes and header constants.
`default_nettype none
package mld_pkg;

	// Header layout.
	localparam int unsigned HEADER_BYTES = 12;
	localparam int unsigned MAGIC_COUNT  = 4;
	localparam int unsigned BODY_BYTES   = 8;

	// Result kinds.
	localparam logic [1:0] KIND_START     = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
	localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;
	localparam logic [1:0] KIND_BAD_SIZE  = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_MAGIC_0  = 3'd0;
	localparam logic [2:0] REG_MAGIC_1  = 3'd1;
	localparam logic [2:0] REG_MAGIC_2  = 3'd2;
	localparam logic [2:0] REG_MAGIC_3  = 3'd3;
	localparam logic [2:0] REG_MAX_SIZE = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [7:0]  MAGIC_0_RST  = 8'd80;
	localparam logic [7:0]  MAGIC_1_RST  = 8'd79;
	localparam logic [7:0]  MAGIC_2_RST  = 8'd77;
	localparam logic [7:0]  MAGIC_3_RST  = 8'd80;
	localparam logic [31:0] MAX_SIZE_RST = 32'hFFFF_FFFF;

	// Configuration seen by the parser.
	typedef struct packed {
		logic [3:0][7:0] magic;
		logic [31:0]     max_size;
	} cfg_t;

	// One result beat.
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] message_id;
		logic [31:0] message_size;
		logic [7:0]  payload_byte;
		logic        last;
	} res_t;

endpackage
`default_nettype wire

// File: hw/rtl/mld_cfg.sv
// Configuration registers of the deframer, written through a plain write port.
`default_nettype none
module mld_cfg
	import mld_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output cfg_t             cfg
);

	logic [3:0][7:0] magic_q;
	logic [31:0]     max_size_q;

	// Register writes; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q[0] <= MAGIC_0_RST;
			magic_q[1] <= MAGIC_1_RST;
			magic_q[2] <= MAGIC_2_RST;
			magic_q[3] <= MAGIC_3_RST;
			max_size_q <= MAX_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAGIC_0:  magic_q[0] <= cfg_data[7:0];
				REG_MAGIC_1:  magic_q[1] <= cfg_data[7:0];
				REG_MAGIC_2:  magic_q[2] <= cfg_data[7:0];
				REG_MAGIC_3:  magic_q[3] <= cfg_data[7:0];
				REG_MAX_SIZE: max_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg.magic    = magic_q;
	assign cfg.max_size = max_size_q;

endmodule
`default_nettype wire

// File: hw/rtl/mld_parse.sv
// Input register and header/payload parser of the deframer.
`default_nettype none
module mld_parse
	import mld_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  cfg_t            cfg,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       res_ready,
	output logic            res_valid,
	output res_t            res
);

	typedef enum logic [5:0] {
		PH_HUNT0   = 6'b000001,
		PH_HUNT1   = 6'b000010,
		PH_HUNT2   = 6'b000100,
		PH_HUNT3   = 6'b001000,
		PH_BODY    = 6'b010000,
		PH_PAYLOAD = 6'b100000
	} phase_t;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        advance;

	phase_t      phase_q,  phase_d;
	logic [3:0]  count_q,  count_d;
	logic [31:0] id_q,     id_d;
	logic [31:0] size_q,   size_d;
	logic [31:0] done_q,   done_d;

	logic [7:0]  exp_magic;
	phase_t      hunt_next;
	logic [31:0] size_new;
	logic [31:0] done_inc;
	logic        emit;

	// The held byte moves on when it makes no result or the result slot is free.
	assign advance  = valid_s1 && (!emit || res_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// Expected magic byte and follow-on phase while hunting.
	always_comb begin
		exp_magic = cfg.magic[0];
		hunt_next = PH_HUNT1;
		case (phase_q)
			PH_HUNT1: begin
				exp_magic = cfg.magic[1];
				hunt_next = PH_HUNT2;
			end
			PH_HUNT2: begin
				exp_magic = cfg.magic[2];
				hunt_next = PH_HUNT3;
			end
			PH_HUNT3: begin
				exp_magic = cfg.magic[3];
				hunt_next = PH_BODY;
			end
			default: ;
		endcase
	end

	assign size_new = {byte_s1, size_q[31:8]};
	assign done_inc = done_q + 32'd1;

	// Next state and result for the held byte.
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		id_d    = id_q;
		size_d  = size_q;
		done_d  = done_q;
		emit    = 1'b0;
		res     = '0;
		case (phase_q)
			PH_BODY: begin
				count_d = count_q + 4'd1;
				if (count_q < 4'(MAGIC_COUNT)) begin
					id_d = {byte_s1, id_q[31:8]};
				end else begin
					size_d = size_new;
				end
				// Last header byte: check the size and open the message, or report a bad size.
				if (count_q == 4'(BODY_BYTES - 1)) begin
					emit = 1'b1;
					res.message_size = size_new;
					if (size_new < 32'(HEADER_BYTES) || size_new > cfg.max_size) begin
						res.kind = KIND_BAD_SIZE;
						phase_d  = PH_HUNT0;
						count_d  = '0;
					end else if (size_new == 32'(HEADER_BYTES)) begin
						res.kind       = KIND_START;
						res.message_id = id_q;
						res.last       = 1'b1;
						phase_d        = PH_HUNT0;
						count_d        = '0;
					end else begin
						res.kind       = KIND_START;
						res.message_id = id_q;
						phase_d        = PH_PAYLOAD;
						done_d         = 32'(HEADER_BYTES);
					end
				end
			end
			PH_PAYLOAD: begin
				emit             = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = byte_s1;
				done_d           = done_inc;
				if (done_inc >= size_q) begin
					res.last = 1'b1;
					phase_d  = PH_HUNT0;
					count_d  = '0;
				end
			end
			default: begin
				// Hunting one of the magic bytes; a mismatch restarts the hunt.
				if (byte_s1 != exp_magic) begin
					emit     = 1'b1;
					res.kind = KIND_BAD_MAGIC;
					phase_d  = PH_HUNT0;
					count_d  = '0;
				end else begin
					phase_d = hunt_next;
					count_d = '0;
				end
			end
		endcase
	end

	assign res_valid = valid_s1 && emit;

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT0;
			count_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			id_q   <= id_d;
			size_q <= size_d;
			done_q <= done_d;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/mld_out.sv
// Result register of the deframer: holds one result beat until it is taken.
`default_nettype none
module mld_out
	import mld_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic res_valid,
	output logic      res_ready,
	input  res_t      res,
	output logic      out_valid,
	input  wire logic out_ready,
	output res_t      out_res
);

	logic valid_q;
	res_t res_q;

	// The slot takes a new beat when empty or when its beat leaves now.
	assign res_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;

endmodule
`default_nettype wire

// File: hw/rtl/magic_length_message_deframer.sv
// Top level of the magic-header, length-prefixed message deframer.
//
//   channel   direction  handshake                      content
//   s_axis    in         s_axis_tvalid / s_axis_tready  one stream byte per beat
//   m_axis    out        m_axis_tvalid / m_axis_tready  start, payload or error beat
//   cfg       in         cfg_we                         magic bytes, maximum size
//
// A byte is taken into the input register and parsed there; its result is
// registered in the result register, from which it leaves on m_axis. One byte is
// accepted every cycle while the output side takes beats. Reset puts the
// parser in the hunt for the first magic byte and loads the configuration
// defaults. When the result register is full and not taken, a byte that
// makes a result waits in the input register.
`default_nettype none
module magic_length_message_deframer
	import mld_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [79:0]      m_axis_tdata,   // [31:0] message_id, [63:32] message_size,
	                                         // [71:64] payload_byte, [79:72] zero
	output logic [1:0]       m_axis_tuser,   // [1:0] kind
	output logic             m_axis_tlast,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	cfg_t cfg;
	res_t res;
	res_t out_res;
	logic res_valid;
	logic res_ready;

	mld_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mld_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res)
	);

	mld_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	// Pack the result beat onto the stream.
	assign m_axis_tdata = {8'd0, out_res.payload_byte, out_res.message_size,
		out_res.message_id};
	assign m_axis_tuser = out_res.kind;
	assign m_axis_tlast = out_res.last;

endmodule
`default_nettype wire

// File: tb/magic_length_message_deframer_test.sv
// Self-checking testbench for the magic-header, length-prefixed message deframer.
`timescale 1ns / 1ps
module magic_length_message_deframer_test
	import mld_pkg::*;
();

	// Parser phases of the predictor: 0..3 await a magic byte.
	localparam logic [2:0] PH_BODY    = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;

	// Register indexes beyond the last register, for ignored writes.
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	localparam logic [2:0] MAGIC_REGS [4] = '{REG_MAGIC_0, REG_MAGIC_1, REG_MAGIC_2, REG_MAGIC_3};

	localparam int SETTING_COUNT   = 5;
	localparam int BYTES_PER_SETTING = 170;

	// Predicts the deframer from the accepted bytes and checks its result beats.
	class frame_scoreboard;
		logic [7:0]  magic [4];
		logic [31:0] max_size;
		logic [2:0]  ph;
		logic [3:0]  body_count;
		logic [31:0] id_sr;
		logic [31:0] size_sr;
		logic [31:0] done_count;
		res_t        awaited_beats [$];
		int          errors;
		int          seen [4];

		function new();
			magic[0] = MAGIC_0_RST;
			magic[1] = MAGIC_1_RST;
			magic[2] = MAGIC_2_RST;
			magic[3] = MAGIC_3_RST;
			max_size = MAX_SIZE_RST;
			errors = 0;
			seen = '{0, 0, 0, 0};
			restart_hunt();
		endfunction

		function void restart_hunt();
			ph = 3'd0;
			body_count = 4'd0;
			id_sr = '0;
			size_sr = '0;
			done_count = '0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				REG_MAGIC_0:  magic[0] = val[7:0];
				REG_MAGIC_1:  magic[1] = val[7:0];
				REG_MAGIC_2:  magic[2] = val[7:0];
				REG_MAGIC_3:  magic[3] = val[7:0];
				REG_MAX_SIZE: max_size = val;
				default: ;
			endcase
		endfunction

		function int pending();
			return awaited_beats.size();
		endfunction

		// Advances the parser by one accepted byte and queues the beat it causes.
		function void take_byte(logic [7:0] b);
			res_t r;
			bit   emit;
			r = '0;
			emit = 1'b0;
			if (ph > PH_PAYLOAD) begin
				restart_hunt();
			end
			if (ph < MAGIC_COUNT) begin
				if (b != magic[ph[1:0]]) begin
					restart_hunt();
					r.kind = KIND_BAD_MAGIC;
					emit = 1'b1;
				end else begin
					ph = ph + 3'd1;
				end
			end else if (ph == PH_BODY) begin
				if (body_count < MAGIC_COUNT) begin
					id_sr = {b, id_sr[31:8]};
				end else begin
					size_sr = {b, size_sr[31:8]};
				end
				body_count = body_count + 4'd1;
				if (body_count == BODY_BYTES) begin
					emit = 1'b1;
					r.message_size = size_sr;
					if (size_sr < HEADER_BYTES || size_sr > max_size) begin
						r.kind = KIND_BAD_SIZE;
						restart_hunt();
					end else if (size_sr == HEADER_BYTES) begin
						r.kind = KIND_START;
						r.message_id = id_sr;
						r.last = 1'b1;
						restart_hunt();
					end else begin
						r.kind = KIND_START;
						r.message_id = id_sr;
						ph = PH_PAYLOAD;
						done_count = HEADER_BYTES;
					end
				end
			end else begin
				// Payload: the byte that reaches the total size closes the message.
				done_count = done_count + 32'd1;
				r.kind = KIND_PAYLOAD;
				r.payload_byte = b;
				emit = 1'b1;
				if (done_count >= size_sr) begin
					r.last = 1'b1;
					restart_hunt();
				end
			end
			if (emit) begin
				awaited_beats.push_back(r);
			end
		endfunction

		// Compares one result beat with the oldest awaited one.
		function void match_beat(res_t got);
			res_t want;
			if (awaited_beats.size() == 0) begin
				$error("result beat with none awaited: kind %0d id %0h size %0h byte %0h last %0d",
					got.kind, got.message_id, got.message_size, got.payload_byte, got.last);
				errors++;
				return;
			end
			want = awaited_beats.pop_front();
			seen[want.kind]++;
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, actual %0d", want.kind, got.kind);
				errors++;
			end
			if (got.message_id !== want.message_id) begin
				$error("message_id: expected %0h, actual %0h", want.message_id, got.message_id);
				errors++;
			end
			if (got.message_size !== want.message_size) begin
				$error("message_size: expected %0h, actual %0h", want.message_size,
					got.message_size);
				errors++;
			end
			if (got.payload_byte !== want.payload_byte) begin
				$error("payload_byte: expected %0h, actual %0h", want.payload_byte,
					got.payload_byte);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	frame_scoreboard sb;
	int              bytes_sent = 0;
	bit              no_gaps = 1'b0;

	magic_length_message_deframer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (no_gaps) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 95) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Offers one byte and waits for the beat to be taken.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = b;
		do @(posedge clk); while (!s_axis_tready);
		sb.take_byte(b);
		bytes_sent++;
	endtask

	task automatic send_header(input logic [31:0] id, input logic [31:0] size);
		for (int i = 0; i < 4; i++) send_byte(sb.magic[i]);
		for (int i = 0; i < 4; i++) send_byte(id[8*i +: 8]);
		for (int i = 0; i < 4; i++) send_byte(size[8*i +: 8]);
	endtask

	// Stops sending and waits until every awaited beat has come out.
	task automatic drain();
		int guard;
		guard = 0;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Register settings for the random part; junk above the magic byte must be dropped.
	task automatic apply_setting(input int s);
		case (s)
			1: begin
				for (int i = 0; i < 4; i++) write_reg(MAGIC_REGS[i], {24'($urandom), 8'h00});
				write_reg(REG_MAX_SIZE, HEADER_BYTES);
				write_reg(REG_SPARE_LO, $urandom);
				write_reg(REG_SPARE_HI, $urandom);
			end
			2: begin
				for (int i = 0; i < 4; i++) write_reg(MAGIC_REGS[i], {24'($urandom), 8'hFF});
				write_reg(REG_MAX_SIZE, 32'hFFFF_FFFF);
			end
			3: begin
				for (int i = 0; i < 4; i++) write_reg(MAGIC_REGS[i], $urandom);
				write_reg(REG_MAX_SIZE, $urandom_range(HEADER_BYTES + 1, 60));
			end
			default: begin
				for (int i = 0; i < 4; i++) write_reg(MAGIC_REGS[i], $urandom);
				write_reg(REG_MAX_SIZE, $urandom | 32'h8000_0000);
			end
		endcase
	endtask

	// One random frame: mostly well-formed messages, the rest broken headers and noise.
	task automatic send_random_frame();
		int              pick;
		int              len;
		longint unsigned room;
		logic [31:0]     id;
		logic [31:0]     size;
		int              k;
		pick = $urandom_range(0, 99);
		id = $urandom;
		if (pick < 62) begin
			room = sb.max_size - HEADER_BYTES;
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(21, 200) : $urandom_range(0, 20);
			if (len > room) begin
				len = int'(room);
			end
			send_header(id, HEADER_BYTES + len);
			repeat (len) send_byte(8'($urandom));
		end else if (pick < 70) begin
			send_header(id, HEADER_BYTES);
		end else if (pick < 78) begin
			send_header(id, $urandom_range(0, HEADER_BYTES - 1));
		end else if (pick < 86) begin
			// Size above the maximum, or below the header when no size is too large.
			if (sb.max_size == 32'hFFFF_FFFF) begin
				size = $urandom_range(0, HEADER_BYTES - 1);
			end else begin
				size = $urandom;
				if (size <= sb.max_size) begin
					size = sb.max_size + 1 + (size % ~sb.max_size);
				end
			end
			send_header(id, size);
		end else if (pick < 94) begin
			k = $urandom_range(0, 3);
			for (int i = 0; i < k; i++) send_byte(sb.magic[i]);
			send_byte(sb.magic[k] ^ 8'($urandom_range(1, 255)));
		end else begin
			// Noise, then break off any magic run it may have started.
			repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
			while (sb.ph != 3'd0 && sb.ph < MAGIC_COUNT) begin
				send_byte(sb.magic[sb.ph[1:0]] ^ 8'($urandom_range(1, 255)));
			end
		end
	endtask

	// Result side: random back-pressure.
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_axis_tready = 1'b0;
				hold--;
			end else begin
				m_axis_tready = 1'b1;
				hold = pick_gap();
			end
		end
	end

	// Result beats are checked at the edge that takes them.
	initial begin
		res_t got;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got.kind = m_axis_tuser;
				got.message_id = m_axis_tdata[31:0];
				got.message_size = m_axis_tdata[63:32];
				got.payload_byte = m_axis_tdata[71:64];
				got.last = m_axis_tlast;
				sb.match_beat(got);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("magic_length_message_deframer_test: errors");
		$finish;
	end

	initial begin
		int start;
		sb = new();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed: bad first byte, bad third magic byte, header-only message with an
		// all-ones id, and a one-byte message with an all-zero id and an all-ones byte.
		send_byte(~sb.magic[0]);
		send_byte(sb.magic[0]);
		send_byte(sb.magic[1]);
		send_byte(~sb.magic[2]);
		send_header(32'hFFFF_FFFF, HEADER_BYTES);
		send_header(32'h0000_0000, HEADER_BYTES + 1);
		send_byte(8'hFF);
		drain();

		// Random part, one stretch per register setting.
		for (int s = 0; s < SETTING_COUNT; s++) begin
			if (s > 0) begin
				drain();
				apply_setting(s);
			end
			start = bytes_sent;
			while (bytes_sent - start < BYTES_PER_SETTING) begin
				no_gaps = ($urandom_range(0, 7) == 0);
				send_random_frame();
				if ($urandom_range(0, 39) == 0) begin
					drain();
				end
			end
		end
		no_gaps = 1'b0;

		drain();
		repeat (10) @(negedge clk);
		if (sb.pending() != 0) begin
			$error("%0d result beats never arrived", sb.pending());
			sb.errors++;
		end

		$display("Sent %0d stream bytes under %0d register settings.", bytes_sent,
			SETTING_COUNT);
		$display("Checked %0d start, %0d payload, %0d bad magic and %0d bad size beats.",
			sb.seen[KIND_START], sb.seen[KIND_PAYLOAD], sb.seen[KIND_BAD_MAGIC],
			sb.seen[KIND_BAD_SIZE]);
		if (sb.errors == 0) begin
			$display("magic_length_message_deframer_test: clean");
		end else begin
			$display("magic_length_message_deframer_test: errors");
		end
		$finish;
	end

endmodule

// File: magic_length_message_deframer.f
hw/rtl/mld_pkg.sv
hw/rtl/mld_cfg.sv
hw/rtl/mld_parse.sv
hw/rtl/mld_out.sv
hw/rtl/magic_length_message_deframer.sv
tb/magic_length_message_deframer_test.sv
